@@ rtl/string_hash_bucket_index_assert.svh @@
// Assertion helpers for the RTL (included by shbi_ctrl).
`ifndef STRING_HASH_BUCKET_INDEX_ASSERT_SVH
`define STRING_HASH_BUCKET_INDEX_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define SHBI_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("shbi assertion failed");

// Next-cycle implication, gated off during reset.
`define SHBI_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("shbi assertion failed");

`endif

@@ rtl/shbi_pkg.sv @@
`timescale 1ns / 1ps
package shbi_pkg;

  localparam int HashW = 32;
  localparam int ByteW = 8;
  localparam int DataW = 32;
  localparam int AddrW = 3;
  localparam int CntW  = $clog2(HashW);

  localparam int MixShl = 10;
  localparam int MixShr = 6;
  localparam int FinShl0 = 3;
  localparam int FinShr = 11;
  localparam int FinShl1 = 15;

  localparam logic [DataW-1:0] TableSizeRst = 32'd1;
  // word index of the table_size register (paddr[2])
  localparam logic RegTableSize = 1'b0;

  typedef struct packed {
    logic mix_en;
    logic fin_en;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

  function automatic logic [HashW-1:0] mix_byte(input logic [HashW-1:0] h_in,
                                                input logic [ByteW-1:0] b);
    logic [HashW-1:0] h;
    h = h_in + {{(HashW-ByteW){1'b0}}, b};
    h = h + (h << MixShl);
    h = h ^ (h >> MixShr);
    return h;
  endfunction

  function automatic logic [HashW-1:0] finalize(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in + (h_in << FinShl0);
    h = h ^ (h >> FinShr);
    h = h + (h << FinShl1);
    return h;
  endfunction

endpackage

@@ rtl/shbi_dp.sv @@
`timescale 1ns / 1ps
module shbi_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  shbi_pkg::dp_cmd_t            cmd,
  input  logic [shbi_pkg::ByteW-1:0]   in_key_byte,
  input  logic [shbi_pkg::DataW-1:0]   table_size,
  output shbi_pkg::dp_sts_t            sts,
  output logic [shbi_pkg::HashW-1:0]   out_hash_value,
  output logic [shbi_pkg::HashW-1:0]   out_bucket_index
);

  localparam logic [shbi_pkg::CntW-1:0] DivLast = shbi_pkg::CntW'(shbi_pkg::HashW - 1);

  logic [shbi_pkg::HashW-1:0] acc_r;
  logic [shbi_pkg::HashW-1:0] hash_r;
  logic [shbi_pkg::HashW-1:0] dvd_r;
  logic [shbi_pkg::HashW-1:0] rem_r;
  logic [shbi_pkg::HashW-1:0] rem_nxt;
  logic [shbi_pkg::CntW-1:0]  cnt_r;
  logic [shbi_pkg::HashW-1:0] out_hash_r;
  logic [shbi_pkg::HashW-1:0] out_bucket_r;
  logic [shbi_pkg::HashW-1:0] fin_hash;
  logic [shbi_pkg::HashW:0]   rem_shift;
  logic [shbi_pkg::HashW:0]   rem_diff;

  assign fin_hash = shbi_pkg::finalize(acc_r);

  // restoring divider, one quotient bit per step
  always_comb begin
    rem_shift = {rem_r, dvd_r[shbi_pkg::HashW-1]};
    rem_diff  = rem_shift - {1'b0, table_size};
    if (!rem_diff[shbi_pkg::HashW]) begin
      rem_nxt = rem_diff[shbi_pkg::HashW-1:0];
    end else begin
      rem_nxt = rem_shift[shbi_pkg::HashW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.fin_en) begin
      acc_r <= '0;
    end else if (cmd.mix_en) begin
      acc_r <= shbi_pkg::mix_byte(acc_r, in_key_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      hash_r <= fin_hash;
      dvd_r  <= fin_hash;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_hash_r   <= hash_r;
      // zero table size: no reduction
      out_bucket_r <= (table_size == '0) ? hash_r : rem_r;
    end
  end

  assign sts.div_last     = (cnt_r == DivLast);
  assign out_hash_value   = out_hash_r;
  assign out_bucket_index = out_bucket_r;

endmodule

@@ rtl/shbi_ctrl.sv @@
`timescale 1ns / 1ps
`include "string_hash_bucket_index_assert.svh"
module shbi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_byte_present,
  input  logic                in_key_end,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  shbi_pkg::dp_sts_t   sts,
  output shbi_pkg::dp_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FIN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   in_accept;
  logic   out_take;
  logic   out_free;

  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_take;

  always_comb begin
    cmd.mix_en   = in_accept && in_byte_present;
    cmd.fin_en   = (state_r == S_FIN);
    cmd.div_step = (state_r == S_DIV);
    cmd.load_out = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_key_end) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `SHBI_ASSERT_NEXT(a_end_starts_fin, clk, rst_n, in_valid && !in_stall && in_key_end, state_r == S_FIN)
  `SHBI_ASSERT_NEXT(a_fin_then_div, clk, rst_n, state_r == S_FIN, state_r == S_DIV)
  `SHBI_ASSERT_NEXT(a_div_ends, clk, rst_n, state_r == S_DIV && sts.div_last, state_r == S_DONE)
  `SHBI_ASSERT_NEXT(a_done_loads, clk, rst_n, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_IDLE)

endmodule

@@ rtl/string_hash_bucket_index.sv @@
`timescale 1ns / 1ps
// One-at-a-time string hash with bucket selection.
// Input channel (in_valid/in_stall): one key byte per word; in_byte_present
// marks a real byte, in_key_end marks the last word of a key. A word with no
// byte and no end changes nothing; an end word with no byte closes the key.
// Output channel (out_valid/out_stall): one word per key with the 32-bit
// hash and hash modulo table_size (the hash itself when table_size is 0).
// Throughput: bytes inside a key are taken one per cycle. After a key end
// word the input stalls through the finalize step, the bit-serial restoring
// divider (one remainder bit per cycle) and the load of the output register.
// out_valid rises as the block returns to idle, when the next input word can
// be taken. A result waiting on out_stall does not block new bytes; only the
// next key end waits (in the load cycle) until the output register frees up.
// table_size is written over the APB port (address 0); the user must write it
// only while idle; the block does not enforce this. Reset value is 1. Reset
// clears the accumulator and both handshakes.
module string_hash_bucket_index (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [shbi_pkg::ByteW-1:0]    in_key_byte,
  input  logic                          in_byte_present,
  input  logic                          in_key_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [shbi_pkg::HashW-1:0]    out_hash_value,
  output logic [shbi_pkg::HashW-1:0]    out_bucket_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [shbi_pkg::AddrW-1:0]    paddr,
  input  logic [shbi_pkg::DataW-1:0]    pwdata,
  output logic [shbi_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [shbi_pkg::DataW-1:0] table_size_r;
  shbi_pkg::dp_cmd_t          cmd;
  shbi_pkg::dp_sts_t          sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= shbi_pkg::TableSizeRst;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == shbi_pkg::RegTableSize) begin
      table_size_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == shbi_pkg::RegTableSize) ? table_size_r : '0;

  shbi_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_byte_present (in_byte_present),
    .in_key_end      (in_key_end),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sts             (sts),
    .cmd             (cmd)
  );

  shbi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_key_byte      (in_key_byte),
    .table_size       (table_size_r),
    .sts              (sts),
    .out_hash_value   (out_hash_value),
    .out_bucket_index (out_bucket_index)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int NumDir = 18;
  localparam int NumPhases = 8;
  localparam int PhaseWords = 170;
  localparam int SettleCycles = 40;
  localparam int WatchLimit = 3000;
  localparam int MaxReports = 10;
  localparam logic [shbi_pkg::AddrW-1:0] TableSizeAddr = {shbi_pkg::RegTableSize, 2'b00};
  localparam logic [shbi_pkg::AddrW-1:0] SpareAddr = {~shbi_pkg::RegTableSize, 2'b00};

  typedef struct packed {
    logic [shbi_pkg::ByteW-1:0] key_byte;
    logic                       present;
    logic                       last;
  } key_word_t;

  typedef struct packed {
    logic [shbi_pkg::HashW-1:0] hash_value;
    logic [shbi_pkg::HashW-1:0] bucket_index;
  } hash_result_t;

  typedef struct packed {
    key_word_t    w;
    logic         typed;
    hash_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [shbi_pkg::ByteW-1:0] in_key_byte = '0;
  logic in_byte_present = 1'b0;
  logic in_key_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [shbi_pkg::HashW-1:0] out_hash_value;
  logic [shbi_pkg::HashW-1:0] out_bucket_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [shbi_pkg::AddrW-1:0] paddr = '0;
  logic [shbi_pkg::DataW-1:0] pwdata = '0;
  logic [shbi_pkg::DataW-1:0] prdata;
  logic pready;

  // predictor state and the hashes still owed by the block
  logic [shbi_pkg::HashW-1:0] acc_hash = '0;
  logic [shbi_pkg::DataW-1:0] bucket_count = shbi_pkg::TableSizeRst;
  hash_result_t hash_q[$];

  int bad_words = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  // directed words; typed rows carry a result readable at a glance
  dir_row_t dir_rows [NumDir] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h0, 32'h0}},  // empty key after reset
    '{'{8'h00, 1'b1, 1'b1}, 1'b1, '{32'h0, 32'h0}},  // lone zero byte
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},               // byteless word, no result
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},               // zero byte mid-key
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b1, 1'b1}, 1'b0, '0},               // end on a real byte
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h55, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hAA, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b0, '0},               // end with no byte after bytes
    '{'{8'h61, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h0, 32'h0}},  // accumulator was cleared
    '{'{8'h7F, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{32'h0, 32'h0}}
  };

  string_hash_bucket_index dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_key_byte(in_key_byte),
    .in_byte_present(in_byte_present),
    .in_key_end(in_key_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hash_value(out_hash_value),
    .out_bucket_index(out_bucket_index),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [shbi_pkg::HashW-1:0] mix_in_byte(
      input logic [shbi_pkg::HashW-1:0] h_in,
      input logic [shbi_pkg::ByteW-1:0] b);
    logic [shbi_pkg::HashW-1:0] h;
    h = h_in + {{(shbi_pkg::HashW - shbi_pkg::ByteW){1'b0}}, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  function automatic logic [shbi_pkg::HashW-1:0] close_hash(
      input logic [shbi_pkg::HashW-1:0] h_in);
    logic [shbi_pkg::HashW-1:0] h;
    h = h_in + (h_in << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // mostly short idle runs, now and then a long one
  function automatic int idle_span();
    if ($urandom_range(9) == 0) return $urandom_range(40, 8);
    return $urandom_range(3, 1);
  endfunction

  task automatic send_word(input key_word_t w, input bit typed,
                           input hash_result_t typed_res);
    hash_result_t r;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (idle_span()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_byte <= w.key_byte;
    in_byte_present <= w.present;
    in_key_end <= w.last;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (w.present) acc_hash = mix_in_byte(acc_hash, w.key_byte);
    if (w.last) begin
      r.hash_value = close_hash(acc_hash);
      r.bucket_index = (bucket_count != 0) ? r.hash_value % bucket_count : r.hash_value;
      acc_hash = '0;
      hash_q.push_back(typed ? typed_res : r);
    end
  endtask

  task automatic reg_write(input logic [shbi_pkg::AddrW-1:0] addr,
                           input logic [shbi_pkg::DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (addr[2] == shbi_pkg::RegTableSize) bucket_count = data;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every owed hash, then let the divider go quiet
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_keys(input int n_words);
    key_word_t w;
    int sent;
    int len;
    bit end_on_byte;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(19)) inside
        [0:1]: len = 0;
        2: len = $urandom_range(64, 17);
        default: len = $urandom_range(16, 1);
      endcase
      end_on_byte = (len > 0) && ($urandom_range(3) != 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) begin
          w = '{8'($urandom), 1'b0, 1'b0};
          send_word(w, 1'b0, '0);
        end
        case ($urandom_range(7))
          0: w.key_byte = 8'h00;
          1: w.key_byte = 8'hFF;
          default: w.key_byte = 8'($urandom);
        endcase
        w.present = 1'b1;
        w.last = (k == len - 1) && end_on_byte;
        send_word(w, 1'b0, '0);
        sent++;
      end
      if (!end_on_byte) begin
        w = '{8'($urandom), 1'b0, 1'b1};
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: check each accepted word, then pick the next stall
  always @(posedge clk) begin
    hash_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (hash_q.size() == 0) begin
        bad_words++;
        if (bad_words <= MaxReports)
          $display("unexpected word: hash %h bucket %h", out_hash_value, out_bucket_index);
      end else begin
        e = hash_q.pop_front();
        if (out_hash_value !== e.hash_value || out_bucket_index !== e.bucket_index) begin
          bad_words++;
          if (bad_words <= MaxReports)
            $display("bad word: hash exp %h got %h, bucket exp %h got %h",
                     e.hash_value, out_hash_value, e.bucket_index, out_bucket_index);
        end
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left = idle_span() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("string_hash_bucket_index: mismatch");
      $finish;
    end
  end

  initial begin
    logic [shbi_pkg::DataW-1:0] size;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NumDir; i++)
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    drain_and_settle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: size = 32'd0;
        1: size = 32'hFFFF_FFFF;
        2: size = 32'd2;
        3: size = $urandom_range(1000, 3);
        4: size = 32'h0001_0000;
        5: size = $urandom;
        6: size = 32'd1;
        default: size = $urandom_range(64, 3);
      endcase
      reg_write(TableSizeAddr, size);
      // no register behind this address; the write must change nothing
      if (ph == 2) reg_write(SpareAddr, $urandom);
      gap_pct = (ph == 0) ? 0 : $urandom_range(60, 10);
      stall_pct = (ph == 0) ? 0 : $urandom_range(60, 10);
      run_keys(PhaseWords);
      drain_and_settle();
    end

    if (bad_words == 0 && hash_q.size() == 0)
      $display("string_hash_bucket_index: match");
    else
      $display("string_hash_bucket_index: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/shbi_pkg.sv
rtl/shbi_dp.sv
rtl/shbi_ctrl.sv
rtl/string_hash_bucket_index.sv
test/tb.sv
